FILE: src/sample_mean_stddev_max_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sample statistics block
// Shorthand for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_MEAN_STDDEV_MAX_TOP_ASSERT_SVH
`define SAMPLE_MEAN_STDDEV_MAX_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define SMSM_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define SMSM_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: src/smsm_pkg.sv
// ---------------------------------------------------------------------------
// Sample statistics package
// Widths, item types, the per-set job record and the back-end state codes.
// ---------------------------------------------------------------------------
package smsm_pkg;

	// Fixed configuration of the statistics block.
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_SAMPLES = 1048576;
	localparam int FRAC_BITS   = 16;

	// Accumulator widths.
	localparam int COUNT_W  = 21;
	localparam int SUM_W    = 37;
	localparam int SUM_SQ_W = 53;
	localparam int SQ_W     = 2 * SAMPLE_BITS;
	localparam int OUT_W    = 32;

	// Back-end arithmetic widths.
	localparam int PROD_W = COUNT_W + SUM_SQ_W;
	localparam int NN_W   = 2 * COUNT_W;
	localparam int DIVN_W = PROD_W + 2 * FRAC_BITS;
	localparam int REM_W  = NN_W + 1;
	localparam int QUO_W  = 64;
	localparam int ROOT_W = 64;
	localparam int STEP_W = $clog2(DIVN_W + 1);

	// Job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [15:0] sample;
		logic        last;
	} sample_item_t;

	typedef struct packed {
		logic [31:0] mean_q16;
		logic [31:0] stddev_q16;
		logic [15:0] peak;
		logic [20:0] sample_count;
		logic        overflow;
	} result_item_t;

	// Totals of one finished set.
	typedef struct packed {
		logic [COUNT_W-1:0]     count;
		logic [SUM_W-1:0]       sum;
		logic [SUM_SQ_W-1:0]    sum_sq;
		logic [SAMPLE_BITS-1:0] peak;
		logic                   overflow;
	} job_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               not_empty;
	} queue_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_SS,
		ST_MUL_NQ,
		ST_MUL_NN,
		ST_DIV_MEAN,
		ST_DIV_VAR,
		ST_SQRT,
		ST_DONE
	} back_state_t;

endpackage

FILE: src/smsm_front.sv
// ---------------------------------------------------------------------------
// Sample statistics front end
// Accepts samples, squares them and accumulates count, sums and peak.
// ---------------------------------------------------------------------------
module smsm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  smsm_pkg::sample_item_t sample_item,
	input  smsm_pkg::queue_stat_t  q_stat,
	output logic                 push,
	output smsm_pkg::job_t       job
);
	import smsm_pkg::*;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SQ_W-1:0]        sq_s1;
	logic                   last_s1;

	logic [COUNT_W-1:0]     count_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_SQ_W-1:0]    sum_sq_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic                   overflow_q;

	logic accept;
	logic at_limit;

	// Hold off samples while a set ending now could find the queue full.
	assign sample_stall = (q_stat.level == LEVEL_W'(QUEUE_DEPTH)) ||
		((q_stat.level == LEVEL_W'(QUEUE_DEPTH - 1)) && valid_s1 && last_s1);
	assign accept = sample_valid && !sample_stall;

	// Stage one registers the sample and its square.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_item.sample;
			sq_s1     <= SQ_W'(sample_item.sample) * SQ_W'(sample_item.sample);
			last_s1   <= sample_item.last;
		end
	end

	// Totals including the sample in stage one; a sample at the count limit is dropped.
	always_comb begin
		at_limit = (count_q == COUNT_W'(MAX_SAMPLES));
		job      = '{count: count_q, sum: sum_q, sum_sq: sum_sq_q, peak: peak_q,
			overflow: overflow_q};
		if (at_limit) begin
			job.overflow = 1'b1;
		end else begin
			job.count  = count_q + COUNT_W'(1);
			job.sum    = sum_q + SUM_W'(sample_s1);
			job.sum_sq = sum_sq_q + SUM_SQ_W'(sq_s1);
			if (sample_s1 > peak_q) begin
				job.peak = sample_s1;
			end
		end
		push = valid_s1 && last_s1;
	end

	// Accumulators restart after the last sample of a set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			sum_q      <= '0;
			sum_sq_q   <= '0;
			peak_q     <= '0;
			overflow_q <= 1'b0;
		end else if (valid_s1) begin
			if (last_s1) begin
				count_q    <= '0;
				sum_q      <= '0;
				sum_sq_q   <= '0;
				peak_q     <= '0;
				overflow_q <= 1'b0;
			end else begin
				count_q    <= job.count;
				sum_q      <= job.sum;
				sum_sq_q   <= job.sum_sq;
				peak_q     <= job.peak;
				overflow_q <= job.overflow;
			end
		end
	end

endmodule

FILE: src/smsm_queue.sv
// ---------------------------------------------------------------------------
// Sample statistics job queue
// A short queue of finished set totals between the front and back ends.
// ---------------------------------------------------------------------------
module smsm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  smsm_pkg::job_t        job_in,
	input  logic                  pop,
	output smsm_pkg::job_t        head,
	output smsm_pkg::queue_stat_t q_stat
);
	import smsm_pkg::*;

	job_t               mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LEVEL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LEVEL_W'(1);
			end
		end
	end

	assign head             = mem_q[rd_ptr_q];
	assign q_stat.level     = level_q;
	assign q_stat.not_empty = (level_q != '0);

endmodule

FILE: src/smsm_back.sv
// ---------------------------------------------------------------------------
// Sample statistics back end
// Turns set totals into mean and deviation with a serial multiplier,
// a restoring divider and a digit-by-digit square root.
// ---------------------------------------------------------------------------
module smsm_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smsm_pkg::job_t         head,
	input  smsm_pkg::queue_stat_t  q_stat,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output smsm_pkg::result_item_t result_item
);
	import smsm_pkg::*;

	localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(SUM_W - 1);
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIVN_W - 1);
	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W / 2 - 1);

	back_state_t state_q, state_nx;

	// Totals of the set being worked on.
	logic [COUNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SUM_SQ_W-1:0]    sumsq_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic                   ovf_q;

	// Serial multiplier.
	logic [PROD_W-1:0] mul_a_q;
	logic [SUM_W-1:0]  mul_b_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] mul_sum;
	logic [PROD_W-1:0] ss_q;
	logic [PROD_W-1:0] num_q;
	logic [NN_W-1:0]   nn_q;

	// Restoring divider.
	logic [NN_W-1:0]   den_q;
	logic [DIVN_W-1:0] dvd_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic              quo_sat_q;
	logic [REM_W-1:0]  rem_sh;
	logic              div_ge;
	logic [REM_W-1:0]  rem_nx;
	logic [QUO_W-1:0]  quo_nx;
	logic              quo_sat_nx;
	logic [OUT_W-1:0]  mean_q;

	// Square root.
	logic [ROOT_W-1:0] x_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] bit_q;
	logic [ROOT_W-1:0] trial;
	logic              sq_ge;

	logic [STEP_W-1:0] step_q;
	logic              step_end;
	logic              load_out;

	logic              out_valid_q;
	result_item_t      out_item_q;

	// One step of each arithmetic unit.
	always_comb begin
		mul_sum    = prod_q + (mul_b_q[0] ? mul_a_q : '0);
		rem_sh     = {rem_q[REM_W-2:0], dvd_q[DIVN_W-1]};
		div_ge     = (rem_sh >= {1'b0, den_q});
		rem_nx     = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
		quo_nx     = {quo_q[QUO_W-2:0], div_ge};
		quo_sat_nx = quo_sat_q | quo_q[QUO_W-1];
		trial      = root_q + bit_q;
		sq_ge      = (x_q >= trial);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state, queue pop and output load.
	always_comb begin
		state_nx = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		step_end = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_stat.not_empty) begin
					pop      = 1'b1;
					state_nx = ST_MUL_SS;
				end
			end
			ST_MUL_SS: begin
				step_end = (step_q == MUL_LAST);
				if (step_end) begin
					state_nx = ST_MUL_NQ;
				end
			end
			ST_MUL_NQ: begin
				step_end = (step_q == MUL_LAST);
				if (step_end) begin
					state_nx = ST_MUL_NN;
				end
			end
			ST_MUL_NN: begin
				step_end = (step_q == MUL_LAST);
				if (step_end) begin
					state_nx = ST_DIV_MEAN;
				end
			end
			ST_DIV_MEAN: begin
				step_end = (step_q == DIV_LAST);
				if (step_end) begin
					state_nx = ST_DIV_VAR;
				end
			end
			ST_DIV_VAR: begin
				step_end = (step_q == DIV_LAST);
				if (step_end) begin
					state_nx = ST_SQRT;
				end
			end
			ST_SQRT: begin
				step_end = (step_q == SQRT_LAST);
				if (step_end) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (step_end || (state_q == ST_IDLE)) begin
			step_q <= '0;
		end else begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Datapath of the multiply, divide and root phases.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					cnt_q   <= head.count;
					sum_q   <= head.sum;
					sumsq_q <= head.sum_sq;
					peak_q  <= head.peak;
					ovf_q   <= head.overflow;
					mul_a_q <= PROD_W'(head.sum);
					mul_b_q <= head.sum;
					prod_q  <= '0;
				end
			end
			ST_MUL_SS, ST_MUL_NQ, ST_MUL_NN: begin
				prod_q  <= mul_sum;
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
				if (step_end) begin
					prod_q <= '0;
					if (state_q == ST_MUL_SS) begin
						// Square of the sum done; next is count times sum of squares.
						ss_q    <= mul_sum;
						mul_a_q <= PROD_W'(sumsq_q);
						mul_b_q <= SUM_W'(cnt_q);
					end else if (state_q == ST_MUL_NQ) begin
						// Variance numerator, clamped at zero.
						num_q   <= (mul_sum < ss_q) ? '0 : (mul_sum - ss_q);
						mul_a_q <= PROD_W'(cnt_q);
						mul_b_q <= SUM_W'(cnt_q);
					end else begin
						// Count squared done; the mean division starts.
						nn_q      <= mul_sum[NN_W-1:0];
						den_q     <= NN_W'(cnt_q);
						dvd_q     <= DIVN_W'(sum_q) << FRAC_BITS;
						rem_q     <= '0;
						quo_q     <= '0;
						quo_sat_q <= 1'b0;
					end
				end
			end
			ST_DIV_MEAN, ST_DIV_VAR: begin
				rem_q     <= rem_nx;
				dvd_q     <= dvd_q << 1;
				quo_q     <= quo_nx;
				quo_sat_q <= quo_sat_nx;
				if (step_end) begin
					if (state_q == ST_DIV_MEAN) begin
						if (quo_sat_nx || (quo_nx[QUO_W-1:OUT_W] != '0)) begin
							mean_q <= '1;
						end else begin
							mean_q <= quo_nx[OUT_W-1:0];
						end
						den_q     <= nn_q;
						dvd_q     <= DIVN_W'(num_q) << (2 * FRAC_BITS);
						rem_q     <= '0;
						quo_q     <= '0;
						quo_sat_q <= 1'b0;
					end else begin
						x_q    <= quo_sat_nx ? '1 : quo_nx;
						root_q <= '0;
						bit_q  <= ROOT_W'(1) << (ROOT_W - 2);
					end
				end
			end
			ST_SQRT: begin
				if (sq_ge) begin
					x_q    <= x_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DONE: begin
				if (load_out) begin
					out_item_q.mean_q16 <= mean_q;
					if (root_q[ROOT_W-1:OUT_W] != '0) begin
						out_item_q.stddev_q16 <= '1;
					end else begin
						out_item_q.stddev_q16 <= root_q[OUT_W-1:0];
					end
					out_item_q.peak         <= peak_q;
					out_item_q.sample_count <= cnt_q;
					out_item_q.overflow     <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_item_q;

endmodule

FILE: src/sample_mean_stddev_max_top.sv
// ---------------------------------------------------------------------------
// Sample mean, standard deviation and maximum
// Top level: front accumulator, job queue and arithmetic back end.
// ---------------------------------------------------------------------------
// Usage:
// Samples arrive on the sample channel (sample_valid, sample_stall,
// sample_item), one per item, with last set on the final sample of a set.
// One result item per set leaves on the result channel (result_valid,
// result_stall, result_item): mean and population deviation in Q.16,
// the peak, the sample count and the overflow flag.
// Samples are taken at one per cycle while sample_stall is low. Each
// finished set goes into a two-entry job queue; the back end works on one
// set at a time (pop, serial multiplier, restoring divider and root one
// bit a cycle, output load) and pops the next only after loading the
// result. Sets that arrive faster than the back end finishes them make
// the front stall its input once the queue is full.
// While the receiver stalls, the result stays in its output register and
// the back end finishes the next set, then waits for the register to free.
// Reset clears the accumulators, the queue and the result valid flag.
// ---------------------------------------------------------------------------
`include "sample_mean_stddev_max_top_assert.svh"

module sample_mean_stddev_max_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	output logic                   sample_stall,
	input  smsm_pkg::sample_item_t sample_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output smsm_pkg::result_item_t result_item
);
	import smsm_pkg::*;

	queue_stat_t q_stat;
	job_t        push_job;
	job_t        head_job;
	logic        q_push;
	logic        q_pop;

	// Accumulation of incoming samples.
	smsm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.q_stat       (q_stat),
		.push         (q_push),
		.job          (push_job)
	);

	// Finished sets waiting for the back end.
	smsm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.job_in (push_job),
		.pop    (q_pop),
		.head   (head_job),
		.q_stat (q_stat)
	);

	// Mean, deviation and result register.
	smsm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head_job),
		.q_stat       (q_stat),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	// A set always holds at least one sample.
	`SMSM_IMPLY(a_count_nonzero, result_valid, result_item.sample_count != '0, "empty set result")
	// Overflow only happens once the count has hit its limit.
	`SMSM_IMPLY(a_overflow_full, result_valid && result_item.overflow, result_item.sample_count == COUNT_W'(MAX_SAMPLES), "overflow below count limit")
	// The mean never exceeds the peak.
	`SMSM_IMPLY(a_mean_le_peak, result_valid, result_item.mean_q16[OUT_W-1:FRAC_BITS] <= result_item.peak, "mean above peak")
	// The front never pushes into a full queue.
	`SMSM_CHECK(a_no_push_full, !(q_push && (q_stat.level == LEVEL_W'(QUEUE_DEPTH))), "push into full queue")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the sample mean, standard deviation and maximum block
// Sends sets of unsigned samples on the sample channel and checks every
// result item against a local model of the count, sum, sum of squares and
// peak. Covers field extremes, constant and two-valued sets, and random
// sets under random idling on both channels.
// ---------------------------------------------------------------------------
module testbench;
	import smsm_pkg::*;

	// Run limit, far above the slowest correct run.
	localparam longint TIMEOUT_NS = 64'd150_000_000;
	// Drain time after the last result, above the back-end latency.
	localparam int SETTLE_CYCLES = 450;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         sample_valid;
	logic         sample_stall;
	sample_item_t sample_item;
	logic         result_valid;
	logic         result_stall;
	result_item_t result_item;

	// Statistics of each finished set, oldest first.
	result_item_t pending_stats[$];
	int           fails = 0;

	// Idling controls shared by the tests.
	bit tx_gaps   = 1'b1;
	bit rx_stalls = 1'b1;

	// Running totals of the set in progress.
	logic [COUNT_W-1:0]     acc_count;
	logic [SUM_W-1:0]       acc_sum;
	logic [SUM_SQ_W-1:0]    acc_sum_sq;
	logic [SAMPLE_BITS-1:0] acc_peak;
	logic                   acc_overflow;

	sample_mean_stddev_max_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_item  (sample_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Floor of the square root of a 64-bit value, two bits per step.
	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] probe;
		rem   = x;
		root  = '0;
		probe = 64'h1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// Mean and population deviation of the totals, in Q.16.
	function automatic result_item_t set_stats();
		result_item_t res;
		logic [63:0]  mean_full;
		logic [127:0] prod_n_sq;
		logic [127:0] prod_sum;
		logic [127:0] diff;
		logic [127:0] quo;
		logic [63:0]  var_q;
		logic [63:0]  root;
		res.mean_q16   = '0;
		res.stddev_q16 = '0;
		if (acc_count != 0) begin
			mean_full = (64'(acc_sum) << FRAC_BITS) / 64'(acc_count);
			res.mean_q16 = (mean_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean_full[31:0];
			// One-pass variance scaled by n squared; clamp a negative difference.
			prod_n_sq = 128'(acc_count) * 128'(acc_sum_sq);
			prod_sum  = 128'(acc_sum) * 128'(acc_sum);
			diff = (prod_n_sq < prod_sum) ? 128'd0 : prod_n_sq - prod_sum;
			diff = diff << (2 * FRAC_BITS);
			quo = diff / (128'(acc_count) * 128'(acc_count));
			var_q = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
			root = int_sqrt(var_q);
			res.stddev_q16 = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
		end
		res.peak         = acc_peak;
		res.sample_count = acc_count;
		res.overflow     = acc_overflow;
		return res;
	endfunction

	function automatic void clear_totals();
		acc_count    = '0;
		acc_sum      = '0;
		acc_sum_sq   = '0;
		acc_peak     = '0;
		acc_overflow = 1'b0;
	endfunction

	// Fold one accepted sample into the totals; a last mark closes the set.
	function automatic void fold_sample(input sample_item_t it);
		logic [SAMPLE_BITS-1:0] s;
		s = it.sample[SAMPLE_BITS-1:0];
		if (acc_count >= MAX_SAMPLES) begin
			acc_overflow = 1'b1;
		end else begin
			acc_count  = acc_count + 1'b1;
			acc_sum    = acc_sum + SUM_W'(s);
			acc_sum_sq = acc_sum_sq + SUM_SQ_W'(s) * SUM_SQ_W'(s);
			if (s > acc_peak)
				acc_peak = s;
		end
		if (it.last) begin
			pending_stats = {pending_stats, set_stats()};
			clear_totals();
		end
	endfunction

	// Send one item after an optional gap and wait until it is accepted.
	task automatic send_sample(input logic [15:0] value, input bit last_flag);
		int           gap;
		sample_item_t it;
		it.sample = value;
		it.last   = last_flag;
		gap = tx_gaps ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_item  <= it;
		do
			@(posedge clk);
		while (sample_stall);
		fold_sample(it);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		sample_valid <= 1'b0;
	endtask

	// Hold the sender until every expected result has come.
	task automatic wait_drained();
		stop_sending();
		while (pending_stats.size() != 0)
			@(posedge clk);
	endtask

	// Receiver stall: random runs of ready and stalled cycles.
	int rx_hold = 0;
	always @(negedge clk) begin
		if (rx_hold == 0) begin
			if (rx_stalls && ($urandom_range(0, 2) == 0)) begin
				result_stall <= 1'b1;
				rx_hold = pick_gap() + 1;
			end else begin
				result_stall <= 1'b0;
				rx_hold = $urandom_range(1, 8);
			end
		end else begin
			rx_hold = rx_hold - 1;
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	// Compare each accepted result item with the oldest expectation.
	always @(posedge clk) begin
		result_item_t exp_r;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_stats.size() == 0) begin
				$error("result item with no expectation waiting");
				fails++;
			end else begin
				exp_r = pending_stats.pop_front();
				check_field("mean_q16", exp_r.mean_q16, result_item.mean_q16);
				check_field("stddev_q16", exp_r.stddev_q16, result_item.stddev_q16);
				check_field("peak", 32'(exp_r.peak), 32'(result_item.peak));
				check_field("sample_count", 32'(exp_r.sample_count),
					32'(result_item.sample_count));
				check_field("overflow", 32'(exp_r.overflow), 32'(result_item.overflow));
			end
		end
	end

	// Extremes of the sample, constant sets, two-valued sets, a short ramp and a peak-first set.
	task automatic test_directed();
		send_sample(16'h0000, 1'b1);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b1);
		send_sample(16'd1, 1'b0);
		send_sample(16'd2, 1'b0);
		send_sample(16'd3, 1'b0);
		send_sample(16'd4, 1'b1);
		send_sample(16'hAAAA, 1'b0);
		send_sample(16'h5555, 1'b1);
		// Peak first, then smaller values.
		send_sample(16'h8000, 1'b0);
		send_sample(16'h7FFF, 1'b0);
		send_sample(16'h0001, 1'b1);
		wait_drained();
	endtask

	// Random sets of mixed length and value style.
	task automatic test_random_sets(input int target);
		int          sent;
		int          len;
		int          style;
		int          r;
		logic [15:0] base;
		logic [15:0] value;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				len = $urandom_range(1, 6);
			else if (r < 85)
				len = $urandom_range(7, 24);
			else if (r < 97)
				len = $urandom_range(25, 80);
			else
				len = $urandom_range(200, 400);
			style = $urandom_range(0, 4);
			base = 16'($urandom);
			tx_gaps   = ($urandom_range(0, 4) != 0);
			rx_stalls = ($urandom_range(0, 4) != 0);
			for (int i = 0; i < len; i++) begin
				case (style)
					0: value = 16'($urandom);
					1: value = base;
					2: value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					3: value = 16'($urandom_range(0, 15));
					default: value = 16'($urandom_range(65000, 65535));
				endcase
				send_sample(value, i == len - 1);
				sent++;
			end
			if ($urandom_range(0, 29) == 0)
				wait_drained();
		end
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
	endtask

	// Main sequence.
	initial begin
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_item  = '0;
		result_stall = 1'b0;
		clear_totals();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_sets(1850);

		stop_sending();
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_stats.size() != 0) begin
			$error("%0d expected result items never arrived", pending_stats.size());
			fails++;
		end
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
